// File: hdl/dimmer_level_transition_engine_top_assert.svh
// Assertion macros shared by the dimmer level engine RTL.
`ifndef DIMMER_LEVEL_TRANSITION_ENGINE_TOP_ASSERT_SVH
`define DIMMER_LEVEL_TRANSITION_ENGINE_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DLTE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define DLTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/dlte_pkg.sv
// Package for the dimmer level engine: codes, payload types and level helpers.
package dlte_pkg;

	localparam logic [2:0] FUNC_MOVE_TO_LEVEL = 3'd0;
	localparam logic [2:0] FUNC_STEP          = 3'd1;
	localparam logic [2:0] FUNC_MOVE          = 3'd2;
	localparam logic [2:0] FUNC_STOP          = 3'd3;
	localparam logic [2:0] FUNC_TICK          = 3'd4;
	localparam logic [2:0] FUNC_OFF           = 3'd5;
	localparam logic [2:0] FUNC_ON            = 3'd6;
	localparam logic [2:0] FUNC_TOGGLE        = 3'd7;

	localparam logic [7:0]  LVL_UNKNOWN  = 8'hFF;
	localparam logic [15:0] TIME_FOREVER = 16'hFFFF;
	localparam logic [15:0] TENTHS       = 16'd10;
	localparam logic [7:0]  MIN_RESET    = 8'h02;
	localparam logic [7:0]  MAX_RESET    = 8'hFE;
	localparam logic [7:0]  LEVEL_RESET  = 8'hFE;

	// Width of the serial divider's dividend, one quotient bit per cycle.
	localparam int DIV_BITS = 9;
	localparam int CNT_W    = $clog2(DIV_BITS);

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  level;
		logic [7:0]  step_size;
		logic        dir_up;
		logic [7:0]  rate;
		logic [15:0] fade_ticks;
		logic        sw_drive;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic [7:0]  level_out;
		logic        output_on;
		logic [15:0] remaining_ticks;
		logic        state_applied;
	} rsp_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] lvl;
		logic       out;
	} apply_t;

	// Below min gives min, else above max gives max, even when min > max.
	function automatic logic [7:0] clamp_lvl(input logic [8:0] v, input logic [7:0] lo,
			input logic [7:0] hi);
		logic [7:0] r;
		if (v < {1'b0, lo}) begin
			r = lo;
		end else if (v > {1'b0, hi}) begin
			r = hi;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	function automatic apply_t apply_level(input logic [7:0] lvl, input logic drive,
			input logic up, input logic cur_out, input logic [7:0] lo, input logic [7:0] hi);
		apply_t r;
		r.ok  = (lvl != LVL_UNKNOWN);
		r.lvl = clamp_lvl({1'b0, lvl}, lo, hi);
		r.out = drive ? (up || (r.lvl > lo)) : cur_out;
		return r;
	endfunction

endpackage

// File: hdl/dlte_ifs.sv
// Valid/ready channel interfaces for commands and results of the dimmer level engine.
interface dlte_cmd_if;
	logic          valid;
	logic          ready;
	dlte_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dlte_rsp_if;
	logic          valid;
	logic          ready;
	dlte_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/dimmer_level_transition_engine_top.sv
// Top level of the dimmer level engine: command decode, serial divider and level state.
//
//   channel  dir  handshake          payload
//   cmd      in   valid/ready        func, level, step_size, dir_up, rate,
//                                    fade_ticks, sw_drive
//   rsp      out  valid/ready        status, level_out, output_on,
//                                    remaining_ticks, state_applied
//   apb      in   psel/penable/pwr   paddr 0 min_level, 4 max_level
//
// A request passes through the accept cycle, the bit-serial restoring divider
// (one quotient bit per cycle) and the commit cycle.
// The commit waits while the previous result is still held in the output register.
// cmd.ready is high only between requests; a result waits in the output register
// until taken and does not block the next accept.
// Reset is asynchronous and puts the level at 254, output off, mode idle.
`include "dimmer_level_transition_engine_top_assert.svh"

module dimmer_level_transition_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	dlte_cmd_if.sink    cmd,
	dlte_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_EXEC} state_t;
	typedef enum logic [1:0] {MODE_IDLE = 2'd0, MODE_TARGET = 2'd1, MODE_MOVE = 2'd2} mode_t;

	state_t                       state_q;
	logic [dlte_pkg::CNT_W-1:0]   cnt_q;
	mode_t                        mode_q;
	logic [7:0]                   min_q, max_q;
	logic [7:0]                   lvl_q, tgt_q, rate_q;
	logic                         on_q, mup_q, drv_q;
	logic [3:0]                   acc_q;
	logic [15:0]                  ticks_q;

	dlte_pkg::cmd_t               cmd_q;
	logic [dlte_pkg::DIV_BITS-1:0] dvd_q;
	logic [15:0]                  rem_q, dsr_q;

	logic                         cmd_acc, rsp_free, cfg_wr;
	logic [dlte_pkg::DIV_BITS-1:0] dvd_init;
	logic [15:0]                  dsr_init;
	logic [7:0]                   diff;
	logic [16:0]                  trial, trial_sub;
	logic                         trial_ge;
	logic [7:0]                   quo, step8;

	mode_t                        nxt_mode;
	logic [7:0]                   nxt_lvl, nxt_tgt, nxt_rate;
	logic                         nxt_on, nxt_mup, nxt_drv, nxt_applied, nxt_status;
	logic [3:0]                   nxt_acc;
	logic [15:0]                  nxt_ticks;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign rsp_free  = !rsp.valid || rsp.ready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = {24'd0, paddr[2] ? max_q : min_q};

	// Divider operands: tenths accumulator plus rate over 10 in move mode, distance over ticks otherwise.
	assign diff = (lvl_q > tgt_q) ? (lvl_q - tgt_q) : (tgt_q - lvl_q);
	always_comb begin
		if (mode_q == MODE_MOVE) begin
			dvd_init = {5'd0, acc_q} + {1'b0, rate_q};
			dsr_init = dlte_pkg::TENTHS;
		end else begin
			dvd_init = {1'b0, diff};
			dsr_init = ticks_q;
		end
	end

	assign trial     = {rem_q, dvd_q[dlte_pkg::DIV_BITS-1]};
	assign trial_ge  = (trial >= {1'b0, dsr_q});
	assign trial_sub = trial - {1'b0, dsr_q};
	assign quo       = dvd_q[7:0];
	assign step8     = quo + {7'd0, (rem_q != 16'd0)};

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd.data;
			dvd_q <= dvd_init;
			dsr_q <= dsr_init;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			rem_q <= trial_ge ? trial_sub[15:0] : trial[15:0];
			dvd_q <= {dvd_q[dlte_pkg::DIV_BITS-2:0], trial_ge};
		end
	end

	always_comb begin
		logic               do_target;
		logic [7:0]         tg;
		logic [7:0]         nx;
		logic [8:0]         t9;
		dlte_pkg::apply_t   ap;
		do_target   = 1'b0;
		tg          = '0;
		nx          = '0;
		t9          = '0;
		ap          = '0;
		nxt_mode    = mode_q;
		nxt_lvl     = lvl_q;
		nxt_on      = on_q;
		nxt_tgt     = tgt_q;
		nxt_rate    = rate_q;
		nxt_acc     = acc_q;
		nxt_mup     = mup_q;
		nxt_drv     = drv_q;
		nxt_ticks   = ticks_q;
		nxt_applied = 1'b0;
		nxt_status  = dlte_pkg::STATUS_OK;
		case (cmd_q.func) inside
			dlte_pkg::FUNC_MOVE_TO_LEVEL: begin
				if (cmd_q.level == dlte_pkg::LVL_UNKNOWN) begin
					nxt_status = dlte_pkg::STATUS_INVALID;
				end else begin
					do_target = 1'b1;
					tg        = cmd_q.level;
				end
			end
			dlte_pkg::FUNC_STEP: begin
				if (cmd_q.dir_up) begin
					t9 = {1'b0, lvl_q} + {1'b0, cmd_q.step_size};
				end else if (lvl_q > cmd_q.step_size) begin
					t9 = {1'b0, lvl_q - cmd_q.step_size};
				end else begin
					t9 = {1'b0, min_q};
				end
				do_target = 1'b1;
				tg        = dlte_pkg::clamp_lvl(t9, min_q, max_q);
			end
			dlte_pkg::FUNC_MOVE: begin
				nxt_mode  = MODE_IDLE;
				nxt_ticks = '0;
				if (cmd_q.rate != 8'd0) begin
					nxt_mode  = MODE_MOVE;
					nxt_mup   = cmd_q.dir_up;
					nxt_rate  = cmd_q.rate;
					nxt_acc   = '0;
					nxt_drv   = cmd_q.sw_drive;
					nxt_ticks = dlte_pkg::TIME_FOREVER;
					if (cmd_q.sw_drive && cmd_q.dir_up && !on_q) begin
						ap = dlte_pkg::apply_level(lvl_q, 1'b1, 1'b1, on_q, min_q, max_q);
						if (ap.ok) begin
							nxt_lvl     = ap.lvl;
							nxt_on      = ap.out;
							nxt_applied = 1'b1;
						end
					end
				end
			end
			dlte_pkg::FUNC_STOP: begin
				nxt_mode  = MODE_IDLE;
				nxt_ticks = '0;
			end
			dlte_pkg::FUNC_TICK: begin
				if (mode_q == MODE_TARGET) begin
					if (lvl_q == tgt_q) begin
						nxt_mode  = MODE_IDLE;
						nxt_ticks = '0;
					end else begin
						if (ticks_q <= 16'd1) begin
							nx        = tgt_q;
							nxt_ticks = '0;
						end else begin
							// step never exceeds the distance, so the down path cannot wrap
							nx = (lvl_q < tgt_q)
								? dlte_pkg::clamp_lvl({1'b0, lvl_q} + {1'b0, step8}, min_q, max_q)
								: dlte_pkg::clamp_lvl({1'b0, lvl_q} - {1'b0, step8}, min_q, max_q);
							nxt_ticks = ticks_q - 16'd1;
						end
						ap = dlte_pkg::apply_level(nx, drv_q, (nx >= lvl_q), on_q, min_q, max_q);
						if (!ap.ok) begin
							nxt_mode = MODE_IDLE;
						end else begin
							nxt_lvl     = ap.lvl;
							nxt_on      = ap.out;
							nxt_applied = 1'b1;
							if (nx == tgt_q) begin
								nxt_mode  = MODE_IDLE;
								nxt_ticks = '0;
							end
						end
					end
				end else if (mode_q == MODE_MOVE) begin
					nxt_acc = rem_q[3:0];
					if (quo != 8'd0) begin
						if (mup_q) begin
							nx = dlte_pkg::clamp_lvl({1'b0, lvl_q} + {1'b0, quo}, min_q, max_q);
						end else if (lvl_q > quo) begin
							nx = dlte_pkg::clamp_lvl({1'b0, lvl_q - quo}, min_q, max_q);
						end else begin
							nx = min_q;
						end
						ap = dlte_pkg::apply_level(nx, drv_q, mup_q, on_q, min_q, max_q);
						if (!ap.ok) begin
							nxt_mode = MODE_IDLE;
						end else begin
							nxt_lvl     = ap.lvl;
							nxt_on      = ap.out;
							nxt_applied = 1'b1;
							if ((mup_q && (nx >= max_q)) || (!mup_q && (nx <= min_q))) begin
								nxt_mode  = MODE_IDLE;
								nxt_ticks = '0;
							end
						end
					end
				end
			end
			dlte_pkg::FUNC_OFF, dlte_pkg::FUNC_ON, dlte_pkg::FUNC_TOGGLE: begin
				nxt_mode    = MODE_IDLE;
				nxt_ticks   = '0;
				nxt_applied = 1'b1;
				if (cmd_q.func == dlte_pkg::FUNC_OFF) begin
					nxt_on = 1'b0;
				end else if (cmd_q.func == dlte_pkg::FUNC_ON) begin
					nxt_on = 1'b1;
				end else begin
					nxt_on = !on_q;
				end
			end
			default: begin
			end
		endcase
		// Start a timed transition, or apply at once when the fade time is zero or endless or there is nothing to spread.
		if (do_target) begin
			nxt_mode  = MODE_IDLE;
			nxt_ticks = '0;
			tg = dlte_pkg::clamp_lvl({1'b0, tg}, min_q, max_q);
			if ((cmd_q.fade_ticks == 16'd0) ||
					(cmd_q.fade_ticks == dlte_pkg::TIME_FOREVER) || (tg == lvl_q)) begin
				ap = dlte_pkg::apply_level(tg, cmd_q.sw_drive, (tg >= lvl_q), on_q,
					min_q, max_q);
				if (ap.ok) begin
					nxt_lvl     = ap.lvl;
					nxt_on      = ap.out;
					nxt_applied = 1'b1;
				end
			end else begin
				nxt_mode  = MODE_TARGET;
				nxt_tgt   = tg;
				nxt_drv   = cmd_q.sw_drive;
				nxt_ticks = cmd_q.fade_ticks;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			mode_q    <= MODE_IDLE;
			min_q     <= dlte_pkg::MIN_RESET;
			max_q     <= dlte_pkg::MAX_RESET;
			lvl_q     <= dlte_pkg::LEVEL_RESET;
			on_q      <= 1'b0;
			tgt_q     <= '0;
			rate_q    <= '0;
			acc_q     <= '0;
			mup_q     <= 1'b0;
			drv_q     <= 1'b0;
			ticks_q   <= '0;
			rsp.valid <= 1'b0;
			rsp.data  <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2]) begin
					max_q <= pwdata[7:0];
				end else begin
					min_q <= pwdata[7:0];
				end
			end
			// drop the taken result; a commit in this cycle reloads the register instead
			if (rsp.valid && rsp.ready && (state_q != S_EXEC)) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						cnt_q   <= dlte_pkg::CNT_W'(dlte_pkg::DIV_BITS - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// hold the commit until the output register is free
					if (rsp_free) begin
						mode_q    <= nxt_mode;
						lvl_q     <= nxt_lvl;
						on_q      <= nxt_on;
						tgt_q     <= nxt_tgt;
						rate_q    <= nxt_rate;
						acc_q     <= nxt_acc;
						mup_q     <= nxt_mup;
						drv_q     <= nxt_drv;
						ticks_q   <= nxt_ticks;
						rsp.valid <= 1'b1;
						rsp.data  <= '{status: nxt_status, level_out: nxt_lvl,
							output_on: nxt_on, remaining_ticks: nxt_ticks,
							state_applied: nxt_applied};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DLTE_ASSERT_NOW(a_move_forever, mode_q == MODE_MOVE, ticks_q == dlte_pkg::TIME_FOREVER, "move mode without endless remaining time")
	`DLTE_ASSERT_NOW(a_move_rate, mode_q == MODE_MOVE, rate_q != 8'd0, "move mode with zero rate")
	`DLTE_ASSERT_NOW(a_target_ticks, mode_q == MODE_TARGET, ticks_q != 16'd0, "target mode with no ticks left")
	`DLTE_ASSERT_NEXT(a_accept_div, cmd.valid && cmd.ready, state_q == S_DIV, "accepted request did not start the divider")

endmodule

// File: sim/dimmer_level_transition_engine_top_tb.sv
// Self-checking testbench for the dimmer level engine: directed table, random requests, APB setup.
`timescale 1ns / 100ps

module dimmer_level_transition_engine_top_tb;

	localparam int          CLK_HALF    = 6;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          PHASE_REQS  = 150;
	localparam int          MAX_GAP     = 40;
	localparam logic [2:0]  REG_MIN     = 3'd0;
	localparam logic [2:0]  REG_MAX     = 3'd4;

	typedef enum logic [1:0] {MODE_IDLE, MODE_TARGET, MODE_MOVE} dim_mode_t;

	typedef struct {
		dlte_pkg::cmd_t req;
		logic           typed;
		dlte_pkg::rsp_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dlte_cmd_if cmd_if();
	dlte_rsp_if rsp_if();

	dimmer_level_transition_engine_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Dimmer state as the block should hold it
	logic [7:0]  lvl_floor   = dlte_pkg::MIN_RESET;
	logic [7:0]  lvl_ceil    = dlte_pkg::MAX_RESET;
	logic [7:0]  dim_lvl     = dlte_pkg::LEVEL_RESET;
	logic        dim_on      = 1'b0;
	dim_mode_t   dim_mode    = MODE_IDLE;
	logic [7:0]  goal_lvl    = 8'd0;
	logic [7:0]  ramp_rate   = 8'd0;
	logic [3:0]  ramp_tenths = 4'd0;
	logic        ramp_up     = 1'b0;
	logic        drive_out   = 1'b0;
	logic [15:0] ticks_to_go = 16'd0;
	logic        applied     = 1'b0;

	dlte_pkg::rsp_t level_reports_q[$];
	dir_row_t    dir_rows[$];
	int unsigned mismatches   = 0;
	int unsigned cycle_count  = 0;
	int unsigned snd_idle_pct = 0;
	int unsigned rcv_stall_pct = 0;

	always #CLK_HALF clk = ~clk;

	function automatic logic [7:0] clip_level(input int unsigned v);
		if (v < lvl_floor) begin
			return lvl_floor;
		end else if (v > lvl_ceil) begin
			return lvl_ceil;
		end
		return v[7:0];
	endfunction

	function automatic logic commit_level(input logic [7:0] lvl, input logic drive, input logic up);
		logic [7:0] l;
		logic       o;
		if (lvl == dlte_pkg::LVL_UNKNOWN) begin
			return 1'b0;
		end
		l = clip_level(lvl);
		o = drive ? (up || (l > lvl_floor)) : dim_on;
		dim_lvl = l;
		dim_on  = o;
		applied = 1'b1;
		return 1'b1;
	endfunction

	function automatic void begin_fade(input logic [7:0] tgt, input logic [15:0] tt,
			input logic drive);
		logic [7:0] t;
		dim_mode    = MODE_IDLE;
		ticks_to_go = 16'd0;
		t = clip_level(tgt);
		if (tt == 16'd0 || tt == dlte_pkg::TIME_FOREVER || t == dim_lvl) begin
			void'(commit_level(t, drive, t >= dim_lvl));
		end else begin
			dim_mode    = MODE_TARGET;
			goal_lvl    = t;
			drive_out   = drive;
			ticks_to_go = tt;
		end
	endfunction

	function automatic dlte_pkg::rsp_t advance_dimmer(input dlte_pkg::cmd_t c);
		dlte_pkg::rsp_t r;
		int unsigned t;
		int unsigned diff;
		int unsigned stp;
		int unsigned acc;
		int unsigned delta;
		logic [7:0]  nxt;
		r.status = dlte_pkg::STATUS_OK;
		applied  = 1'b0;
		case (c.func)
			dlte_pkg::FUNC_MOVE_TO_LEVEL: begin
				if (c.level == dlte_pkg::LVL_UNKNOWN) begin
					r.status = dlte_pkg::STATUS_INVALID;
				end else begin
					begin_fade(c.level, c.fade_ticks, c.sw_drive);
				end
			end
			dlte_pkg::FUNC_STEP: begin
				t = dim_lvl;
				if (c.dir_up) begin
					t = t + c.step_size;
				end else begin
					t = (t > c.step_size) ? t - c.step_size : lvl_floor;
				end
				begin_fade(clip_level(t), c.fade_ticks, c.sw_drive);
			end
			dlte_pkg::FUNC_MOVE: begin
				dim_mode    = MODE_IDLE;
				ticks_to_go = 16'd0;
				if (c.rate != 8'd0) begin
					dim_mode    = MODE_MOVE;
					ramp_up     = c.dir_up;
					ramp_rate   = c.rate;
					ramp_tenths = 4'd0;
					drive_out   = c.sw_drive;
					ticks_to_go = dlte_pkg::TIME_FOREVER;
					if (c.sw_drive && c.dir_up && !dim_on) begin
						void'(commit_level(dim_lvl, 1'b1, 1'b1));
					end
				end
			end
			dlte_pkg::FUNC_STOP: begin
				dim_mode    = MODE_IDLE;
				ticks_to_go = 16'd0;
			end
			dlte_pkg::FUNC_TICK: begin
				if (dim_mode == MODE_TARGET) begin
					if (dim_lvl == goal_lvl) begin
						dim_mode    = MODE_IDLE;
						ticks_to_go = 16'd0;
					end else begin
						if (ticks_to_go <= 16'd1) begin
							nxt = goal_lvl;
							ticks_to_go = 16'd0;
						end else begin
							diff = (dim_lvl < goal_lvl) ? goal_lvl - dim_lvl : dim_lvl - goal_lvl;
							stp  = (diff + ticks_to_go - 1) / ticks_to_go;
							if (stp == 0) begin
								stp = 1;
							end
							nxt = (dim_lvl < goal_lvl) ? clip_level(dim_lvl + stp)
								: clip_level(dim_lvl - stp);
							ticks_to_go = ticks_to_go - 16'd1;
						end
						// a refused level drops to idle but keeps the tick count
						if (!commit_level(nxt, drive_out, nxt >= dim_lvl)) begin
							dim_mode = MODE_IDLE;
						end else if (nxt == goal_lvl) begin
							dim_mode    = MODE_IDLE;
							ticks_to_go = 16'd0;
						end
					end
				end else if (dim_mode == MODE_MOVE) begin
					acc = ramp_tenths + ramp_rate;
					delta = acc / dlte_pkg::TENTHS;
					ramp_tenths = 4'(acc % dlte_pkg::TENTHS);
					if (delta != 0) begin
						if (ramp_up) begin
							nxt = clip_level(dim_lvl + delta);
						end else begin
							nxt = (dim_lvl > delta) ? clip_level(dim_lvl - delta) : lvl_floor;
						end
						if (!commit_level(nxt, drive_out, ramp_up)) begin
							dim_mode = MODE_IDLE;
						end else if ((ramp_up && nxt >= lvl_ceil) ||
								(!ramp_up && nxt <= lvl_floor)) begin
							dim_mode    = MODE_IDLE;
							ticks_to_go = 16'd0;
						end
					end
				end
			end
			default: begin
				dim_mode    = MODE_IDLE;
				ticks_to_go = 16'd0;
				if (c.func == dlte_pkg::FUNC_OFF) begin
					dim_on = 1'b0;
				end else if (c.func == dlte_pkg::FUNC_ON) begin
					dim_on = 1'b1;
				end else begin
					dim_on = ~dim_on;
				end
				applied = 1'b1;
			end
		endcase
		r.level_out       = dim_lvl;
		r.output_on       = dim_on;
		r.remaining_ticks = ticks_to_go;
		r.state_applied   = applied;
		return r;
	endfunction

	function automatic dir_row_t req_row(input logic [2:0] f, input logic [7:0] lvl,
			input logic [7:0] stp, input logic up, input logic [7:0] rate,
			input logic [15:0] tt, input logic onoff, input logic typed,
			input dlte_pkg::rsp_t want);
		dir_row_t d;
		d.req.func       = f;
		d.req.level      = lvl;
		d.req.step_size  = stp;
		d.req.dir_up     = up;
		d.req.rate       = rate;
		d.req.fade_ticks = tt;
		d.req.sw_drive   = onoff;
		d.typed = typed;
		d.want  = want;
		return d;
	endfunction

	// Ticks are the most frequent command, so fades and ramps can run to completion
	function automatic dlte_pkg::cmd_t rand_level_cmd();
		dlte_pkg::cmd_t c;
		int unsigned    pick;
		c.level     = 8'($urandom_range(255));
		c.step_size = 8'($urandom_range(255));
		c.dir_up    = 1'($urandom_range(1));
		c.sw_drive  = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 48) begin
			c.func = dlte_pkg::FUNC_TICK;
		end else if (pick < 62) begin
			c.func = dlte_pkg::FUNC_MOVE_TO_LEVEL;
		end else if (pick < 72) begin
			c.func = dlte_pkg::FUNC_STEP;
		end else if (pick < 82) begin
			c.func = dlte_pkg::FUNC_MOVE;
		end else if (pick < 86) begin
			c.func = dlte_pkg::FUNC_STOP;
		end else if (pick < 90) begin
			c.func = dlte_pkg::FUNC_OFF;
		end else if (pick < 94) begin
			c.func = dlte_pkg::FUNC_ON;
		end else begin
			c.func = dlte_pkg::FUNC_TOGGLE;
		end
		case ($urandom_range(9))
			0: c.fade_ticks = 16'd0;
			1: c.fade_ticks = dlte_pkg::TIME_FOREVER;
			2: c.fade_ticks = 16'($urandom_range(65535));
			default: c.fade_ticks = 16'($urandom_range(12, 1));
		endcase
		case ($urandom_range(7))
			0: c.rate = 8'd0;
			1, 2: c.rate = 8'($urandom_range(30, 1));
			default: c.rate = 8'($urandom_range(255));
		endcase
		if ($urandom_range(15) == 0) begin
			c.level = dlte_pkg::LVL_UNKNOWN;
		end
		return c;
	endfunction

	task automatic send_level_cmd(input dlte_pkg::cmd_t c, input logic typed,
			input dlte_pkg::rsp_t want);
		int unsigned    gap;
		dlte_pkg::rsp_t predicted;
		gap = 0;
		while (snd_idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < snd_idle_pct) begin
			gap++;
		end
		repeat (gap) begin
			@(negedge clk);
			cmd_if.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= c;
		do begin
			@(posedge clk);
		end while (!cmd_if.ready);
		predicted = advance_dimmer(c);
		level_reports_q.push_back(typed ? want : predicted);
	endtask

	// Hold off new requests until every report is back
	task automatic drain_reports();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (level_reports_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		if (addr == REG_MIN) begin
			lvl_floor = value;
		end else begin
			lvl_ceil = value;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_idling(input int unsigned sel);
		case (sel)
			0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
			1: begin snd_idle_pct = 46; rcv_stall_pct = 0;  end
			2: begin snd_idle_pct = 0;  rcv_stall_pct = 46; end
			default: begin snd_idle_pct = 16; rcv_stall_pct = 16; end
		endcase
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(negedge clk) begin
		rsp_if.ready <= (rcv_stall_pct == 0) || ($urandom_range(99) >= rcv_stall_pct);
	end

	always @(posedge clk) begin
		dlte_pkg::rsp_t got;
		dlte_pkg::rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (level_reports_q.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual %p", $time, got);
				mismatches++;
			end else begin
				want = level_reports_q.pop_front();
				check_field("status", want.status, got.status);
				check_field("level_out", want.level_out, got.level_out);
				check_field("output_on", want.output_on, got.output_on);
				check_field("remaining_ticks", want.remaining_ticks, got.remaining_ticks);
				check_field("state_applied", want.state_applied, got.state_applied);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] floor_set[7];
		logic [7:0] ceil_set[7];
		logic [7:0] lo;
		logic [7:0] hi;
		floor_set = '{8'd2, 8'd0, 8'd0, 8'd254, 8'd180, 8'd20, 8'd0};
		ceil_set  = '{8'd254, 8'd254, 8'd0, 8'd254, 8'd40, 8'd230, 8'd0};
		arst_n       = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.data  = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;

		// idle tick, rejected level, output commands, instant and faded moves, then ticks, stop, steps and rate moves
		dir_rows.push_back(req_row(dlte_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b1, '{dlte_pkg::STATUS_OK, 8'd254, 1'b0, 16'd0, 1'b0}));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE_TO_LEVEL, dlte_pkg::LVL_UNKNOWN, 8'hFF,
			1'b1, 8'hFF, dlte_pkg::TIME_FOREVER, 1'b1, 1'b1,
			'{dlte_pkg::STATUS_INVALID, 8'd254, 1'b0, 16'd0, 1'b0}));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_ON, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b1, '{dlte_pkg::STATUS_OK, 8'd254, 1'b1, 16'd0, 1'b1}));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_OFF, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b1, '{dlte_pkg::STATUS_OK, 8'd254, 1'b0, 16'd0, 1'b1}));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_TOGGLE, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b1, '{dlte_pkg::STATUS_OK, 8'd254, 1'b1, 16'd0, 1'b1}));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE_TO_LEVEL, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0,
			1'b1, 1'b1, '{dlte_pkg::STATUS_OK, 8'd2, 1'b0, 16'd0, 1'b1}));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE_TO_LEVEL, 8'd254, 8'd0, 1'b0, 8'd0,
			dlte_pkg::TIME_FOREVER, 1'b1, 1'b1,
			'{dlte_pkg::STATUS_OK, 8'd254, 1'b1, 16'd0, 1'b1}));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE_TO_LEVEL, 8'd100, 8'd0, 1'b0, 8'd0,
			16'd5, 1'b0, 1'b1, '{dlte_pkg::STATUS_OK, 8'd254, 1'b1, 16'd5, 1'b0}));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE_TO_LEVEL, dlte_pkg::LVL_UNKNOWN, 8'd0,
			1'b0, 8'd0, 16'd3, 1'b0, 1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_STOP, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_STEP, 8'd0, 8'hFF, 1'b1, 8'd0, 16'd0, 1'b1,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_STEP, 8'd0, 8'hFF, 1'b0, 8'd0, 16'd3, 1'b1,
			1'b0, '0));
		repeat (4) begin
			dir_rows.push_back(req_row(dlte_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0,
				1'b0, 1'b0, '0));
		end
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE, 8'd0, 8'd0, 1'b1, 8'hFF, 16'd0, 1'b1,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE, 8'd0, 8'd0, 1'b0, 8'd7, 16'd0, 1'b1,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 1'b0,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE, 8'd0, 8'd0, 1'b1, 8'd0, 16'd0, 1'b1,
			1'b0, '0));
		dir_rows.push_back(req_row(dlte_pkg::FUNC_MOVE_TO_LEVEL, 8'd254, 8'd0, 1'b0, 8'd0,
			16'hFFFE, 1'b0, 1'b0, '0));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		set_idling(0);
		foreach (dir_rows[i]) begin
			send_level_cmd(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int p = 0; p < 7; p++) begin
			drain_reports();
			lo = floor_set[p];
			hi = ceil_set[p];
			if (p == 6) begin
				lo = 8'($urandom_range(254));
				hi = 8'($urandom_range(254));
			end
			apb_write(REG_MIN, lo);
			apb_write(REG_MAX, hi);
			set_idling((p + 1) % 4);
			for (int i = 0; i < PHASE_REQS; i++) begin
				if ($urandom_range(79) == 0) begin
					drain_reports();
				end
				send_level_cmd(rand_level_cmd(), 1'b0, '0);
			end
		end

		drain_reports();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
